### src/rl2_pkg.sv
package rl2_pkg;

  // Build-time configuration.
  localparam int SAMPLE_WIDTH     = 24;  // 8 .. 24
  localparam int MAX_LENGTH       = 1024; // 2 .. 1024
  localparam int RESULT_FRAC_BITS = 16;  // 8 .. 24

  // Fixed field and state widths.
  localparam int IN_W    = 24;
  localparam int RATIO_W = 32;
  localparam int DIFF_W  = 60;
  localparam int REF_W   = 58;
  localparam int COUNT_W = 11;

  // Width of the squared magnitudes.
  localparam int DSQ_W = 2 * (SAMPLE_WIDTH + 1);
  localparam int RSQ_W = 2 * SAMPLE_WIDTH;

  // Divider: the numerator is the difference sum scaled by 2^(2F).
  localparam int QUO_W      = 64;
  localparam int DIV_W      = DIFF_W + 2 * RESULT_FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_W);

  // Job queue between the accumulator and the divide/root unit (power of two).
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [DIFF_W-1:0] diff_sum;
    logic [REF_W-1:0]  ref_sum;
    logic              overflow;
  } rl2_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rl2_q_stat_t;

endpackage

### src/rl2_in_if.sv
interface rl2_in_if;
  import rl2_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] x_value;
  logic signed [IN_W-1:0] y_value;
  logic                   last_element;

  modport source (output valid, output x_value, output y_value, output last_element,
                  input ready);
  modport sink (input valid, input x_value, input y_value, input last_element,
                output ready);
endinterface

### src/rl2_out_if.sv
interface rl2_out_if;
  import rl2_pkg::*;

  logic               valid;
  logic               ready;
  logic [RATIO_W-1:0] ratio;
  logic               zero_reference;
  logic               overflowed;

  modport source (output valid, output ratio, output zero_reference, output overflowed,
                  input ready);
  modport sink (input valid, input ratio, input zero_reference, input overflowed,
                output ready);
endinterface

### src/rl2_front.sv
module rl2_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [rl2_pkg::IN_W-1:0] in_x_value,
  input  logic [rl2_pkg::IN_W-1:0] in_y_value,
  input  logic                  in_last_element,
  input  rl2_pkg::rl2_q_stat_t  q_stat,
  output logic                  push,
  output rl2_pkg::rl2_job_t     push_job
);
  import rl2_pkg::*;

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_LENGTH);

  logic [COUNT_W-1:0] count_r, count_nxt;

  logic                    s1_valid_r, s1_last_r, s1_ovf_r;
  logic [SAMPLE_WIDTH:0]   s1_dmag_r;
  logic [SAMPLE_WIDTH-1:0] s1_rmag_r;

  logic             s2_valid_r, s2_last_r, s2_ovf_r;
  logic [DSQ_W-1:0] s2_dsq_r;
  logic [RSQ_W-1:0] s2_rsq_r;

  logic [DIFF_W-1:0] diff_sum_r, diff_sum_nxt;
  logic [REF_W-1:0]  ref_sum_r, ref_sum_nxt;
  logic              ovf_seen_r, ovf_seen_nxt;

  logic                           adv, accept;
  logic [SAMPLE_WIDTH-1:0]        xs, ys;
  logic signed [SAMPLE_WIDTH:0]   xe, ye, dif;
  logic [SAMPLE_WIDTH:0]          dmag;
  logic [SAMPLE_WIDTH-1:0]        rmag;
  logic [DIFF_W:0]                diff_add;
  logic [REF_W:0]                 ref_add;

  // The whole pipeline holds only when a finished vector cannot enter the queue.
  assign adv      = !(s2_valid_r && s2_last_r && q_stat.full);
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  assign xs   = in_x_value[SAMPLE_WIDTH-1:0];
  assign ys   = in_y_value[SAMPLE_WIDTH-1:0];
  assign xe   = $signed({xs[SAMPLE_WIDTH-1], xs});
  assign ye   = $signed({ys[SAMPLE_WIDTH-1], ys});
  assign dif  = xe - ye;
  assign dmag = dif[SAMPLE_WIDTH] ? (SAMPLE_WIDTH+1)'(-dif) : (SAMPLE_WIDTH+1)'(dif);
  assign rmag = xs[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-xs) : xs;

  always_comb begin
    if (in_last_element) begin
      count_nxt = '0;
    end else if (count_r < MAX_COUNT) begin
      count_nxt = count_r + 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  // A carry out of either sum means saturation: the sum is set to all ones.
  assign diff_add = {1'b0, diff_sum_r} + (DIFF_W+1)'(s2_dsq_r);
  assign ref_add  = {1'b0, ref_sum_r} + (REF_W+1)'(s2_rsq_r);

  always_comb begin
    diff_sum_nxt = diff_sum_r;
    ref_sum_nxt  = ref_sum_r;
    ovf_seen_nxt = ovf_seen_r;
    if (s2_valid_r) begin
      if (s2_ovf_r) begin
        diff_sum_nxt = '1;
        ref_sum_nxt  = '1;
        ovf_seen_nxt = 1'b1;
      end else begin
        diff_sum_nxt = diff_add[DIFF_W] ? '1 : diff_add[DIFF_W-1:0];
        ref_sum_nxt  = ref_add[REF_W] ? '1 : ref_add[REF_W-1:0];
      end
    end
  end

  assign push              = adv && s2_valid_r && s2_last_r;
  assign push_job.diff_sum = diff_sum_nxt;
  assign push_job.ref_sum  = ref_sum_nxt;
  assign push_job.overflow = ovf_seen_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      diff_sum_r <= '0;
      ref_sum_r  <= '0;
      ovf_seen_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      if (accept) begin
        count_r <= count_nxt;
      end
      if (push) begin
        diff_sum_r <= '0;
        ref_sum_r  <= '0;
        ovf_seen_r <= 1'b0;
      end else begin
        diff_sum_r <= diff_sum_nxt;
        ref_sum_r  <= ref_sum_nxt;
        ovf_seen_r <= ovf_seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last_r <= in_last_element;
      s1_ovf_r  <= (count_r >= MAX_COUNT);
      s1_dmag_r <= dmag;
      s1_rmag_r <= rmag;
      s2_last_r <= s1_last_r;
      s2_ovf_r  <= s1_ovf_r;
      s2_dsq_r  <= DSQ_W'(s1_dmag_r) * DSQ_W'(s1_dmag_r);
      s2_rsq_r  <= RSQ_W'(s1_rmag_r) * RSQ_W'(s1_rmag_r);
    end
  end
endmodule

### src/rl2_queue.sv
module rl2_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rl2_pkg::rl2_job_t    push_job,
  input  logic                 pop,
  output rl2_pkg::rl2_job_t    pop_job,
  output rl2_pkg::rl2_q_stat_t q_stat
);
  import rl2_pkg::*;

  rl2_job_t           entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] fill_r;

  assign q_stat.full  = (fill_r == Q_CNT_W'(Q_DEPTH));
  assign q_stat.empty = (fill_r == '0);
  assign pop_job      = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end
endmodule

### src/rl2_back.sv
module rl2_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rl2_pkg::rl2_q_stat_t        q_stat,
  input  rl2_pkg::rl2_job_t           pop_job,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rl2_pkg::RATIO_W-1:0] out_ratio,
  output logic                        out_zero_reference,
  output logic                        out_overflowed
);
  import rl2_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SQRT = 4'b0100,
    ST_DONE = 4'b1000
  } bk_state_t;

  localparam logic [DIV_CNT_W-1:0] QUO_LIM = DIV_CNT_W'(QUO_W);

  bk_state_t state_r, state_nxt;

  logic [DIV_W-1:0]     num_r, num_nxt;
  logic [REF_W-1:0]     den_r, den_nxt;
  logic [REF_W-1:0]     rem_r, rem_nxt;
  logic [QUO_W-1:0]     quo_r, quo_nxt;
  logic                 big_r, big_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [QUO_W-1:0]     sq_v_r, sq_v_nxt;
  logic [QUO_W-1:0]     sq_res_r, sq_res_nxt;
  logic [QUO_W-1:0]     sq_bit_r, sq_bit_nxt;
  logic [RATIO_W-1:0]   ratio_r, ratio_nxt;
  logic                 zero_r, zero_nxt;
  logic                 ovf_r, ovf_nxt;

  logic               out_valid_r;
  logic [RATIO_W-1:0] out_ratio_r;
  logic               out_zero_r, out_ovf_r;

  logic [REF_W:0]   trial;
  logic             ge;
  logic [QUO_W-1:0] sq_sum;
  logic             load_out;

  assign trial  = {rem_r, num_r[DIV_W-1]};
  assign ge     = trial >= {1'b0, den_r};
  assign sq_sum = sq_res_r + sq_bit_r;

  assign pop      = (state_r == ST_IDLE) && !q_stat.empty;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt  = state_r;
    num_nxt    = num_r;
    den_nxt    = den_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    big_nxt    = big_r;
    cnt_nxt    = cnt_r;
    sq_v_nxt   = sq_v_r;
    sq_res_nxt = sq_res_r;
    sq_bit_nxt = sq_bit_r;
    ratio_nxt  = ratio_r;
    zero_nxt   = zero_r;
    ovf_nxt    = ovf_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          num_nxt  = {pop_job.diff_sum, {(2 * RESULT_FRAC_BITS){1'b0}}};
          den_nxt  = pop_job.ref_sum;
          rem_nxt  = '0;
          quo_nxt  = '0;
          big_nxt  = 1'b0;
          cnt_nxt  = DIV_CNT_W'(DIV_W - 1);
          ovf_nxt  = pop_job.overflow;
          zero_nxt = (pop_job.ref_sum == '0);
          if (pop_job.ref_sum == '0) begin
            ratio_nxt = '1;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        // One quotient bit per cycle; bits at weight 2^64 and up only mark saturation.
        rem_nxt = ge ? REF_W'(trial - {1'b0, den_r}) : trial[REF_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], ge};
        big_nxt = big_r || (ge && (cnt_r >= QUO_LIM));
        num_nxt = {num_r[DIV_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          if (big_nxt) begin
            ratio_nxt = '1;
            state_nxt = ST_DONE;
          end else begin
            sq_v_nxt   = quo_nxt;
            sq_res_nxt = '0;
            sq_bit_nxt = QUO_W'(1) << (QUO_W - 2);
            state_nxt  = ST_SQRT;
          end
        end
      end
      ST_SQRT: begin
        if (sq_v_r >= sq_sum) begin
          sq_v_nxt   = sq_v_r - sq_sum;
          sq_res_nxt = (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_nxt = sq_res_r >> 1;
        end
        sq_bit_nxt = sq_bit_r >> 2;
        if (sq_bit_r[0]) begin
          // The root of a 64-bit value always fits the 32-bit ratio.
          ratio_nxt = sq_res_nxt[RATIO_W-1:0];
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    big_r    <= big_nxt;
    cnt_r    <= cnt_nxt;
    sq_v_r   <= sq_v_nxt;
    sq_res_r <= sq_res_nxt;
    sq_bit_r <= sq_bit_nxt;
    ratio_r  <= ratio_nxt;
    zero_r   <= zero_nxt;
    ovf_r    <= ovf_nxt;
    if (load_out) begin
      out_ratio_r <= ratio_r;
      out_zero_r  <= zero_r;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ratio          = out_ratio_r;
  assign out_zero_reference = out_zero_r;
  assign out_overflowed     = out_ovf_r;
endmodule

### src/relative_l2_norm_difference.sv
// Relative L2 error norm ||x - y|| / ||x|| of two streamed vectors. The block
// takes one (x, y) element pair per cycle and returns one unsigned Q16.16 ratio
// per vector, on the pair marked last. A three-stage accumulator (magnitudes,
// squares, saturating sums) feeds a two-entry job queue; a shared sequential
// unit then runs a restoring divide, one quotient bit per cycle, and a
// bit-by-bit square root. That unit takes one job at a time while idle and
// hands each ratio to the output register; it skips the root when the quotient
// saturates, and both steps when the reference norm is zero. Elements keep
// streaming at one per cycle while earlier vectors are in the queue; input
// stalls only when a vector ends and the queue holds two unfinished jobs.
// A zero reference norm gives an all-ones ratio with zero_reference set, and
// a vector longer than 1024 pairs saturates both sums and sets overflowed.
module relative_l2_norm_difference (
  input logic clk,
  input logic rst_n,
  rl2_in_if.sink    in_pairs,
  rl2_out_if.source out_result
);
  import rl2_pkg::*;

  rl2_q_stat_t q_stat;
  rl2_job_t    push_job, pop_job;
  logic        push, pop;

  rl2_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_pairs.valid),
    .in_ready        (in_pairs.ready),
    .in_x_value      (in_pairs.x_value),
    .in_y_value      (in_pairs.y_value),
    .in_last_element (in_pairs.last_element),
    .q_stat          (q_stat),
    .push            (push),
    .push_job        (push_job)
  );

  rl2_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  rl2_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_stat             (q_stat),
    .pop_job            (pop_job),
    .pop                (pop),
    .out_valid          (out_result.valid),
    .out_ready          (out_result.ready),
    .out_ratio          (out_result.ratio),
    .out_zero_reference (out_result.zero_reference),
    .out_overflowed     (out_result.overflowed)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("job written into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("job read from an empty queue");

  a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pairs.ready |-> q_stat.full)
    else $error("input stalled while the queue had room");

  a_zero_ref_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (out_result.valid && out_result.zero_reference) |-> (out_result.ratio == '1))
    else $error("zero reference norm without an all-ones ratio");
`endif
endmodule
